>>> rtl/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types and codes for the positional sequence store: command and
// status codes, the request and response words, and the cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package pss_pkg;

    // Command codes (request word)
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_DUMP   = 2'd2;

    // Status codes (response word)
    localparam logic [2:0] STAT_DONE      = 3'd0;
    localparam logic [2:0] STAT_UNDERFLOW = 3'd1;
    localparam logic [2:0] STAT_FULL      = 3'd2;
    localparam logic [2:0] STAT_ELEMENT   = 3'd3;
    localparam logic [2:0] STAT_EMPTY     = 3'd4;

    localparam int WORD_W = 32;
    localparam int POS_W  = 8;
    localparam int LEN_W  = 6;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        logic [1:0]       command;
        word_t            value;
        logic [POS_W-1:0] position;
    } req_word_t;

    typedef struct packed {
        logic [2:0]       status;
        word_t            element;
        logic [LEN_W-1:0] length;
        logic             last;
    } rsp_word_t;

    // What every cell in the chain does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } cell_op_t;

    // Broadcast to all cells
    typedef struct packed {
        cell_op_t         op;
        logic [POS_W-1:0] pos;   // insert/delete index, already clamped
        logic [POS_W-1:0] tail;  // index of the last stored element
        word_t            word;  // new word (insert) or head word (rotate)
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/pss_if.sv
// ----------------------------------------------------------------------------
// pss_req_if / pss_rsp_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
`default_nettype none

interface pss_req_if;
    logic               valid;
    logic               ready;
    pss_pkg::req_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pss_rsp_if;
    logic               valid;
    logic               ready;
    pss_pkg::rsp_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/positional_sequence_store_core.sv
// ----------------------------------------------------------------------------
// positional_sequence_store_core
// Ordered store of up to CAPACITY signed words with positional insert and
// delete and an in-order dump, built as a chain of shifting cells.
// ----------------------------------------------------------------------------
// Insert and delete shift the whole cell chain in the cycle the request word
// is accepted and give one response word on the next cycle, so they run at
// one request per cycle while the response side keeps up. A dump rotates the
// chain once per cycle while the response side keeps up, the head cell feeding
// the response register, and after N rotations of N stored words it is back
// in its original order; an empty dump answers with a single empty-status
// word. No new request is taken while a dump is streaming. The response
// register decouples the two sides. Stored words need no clearing after reset.
`default_nettype none

module positional_sequence_store_core #(
    parameter int CAPACITY = 32
) (
    input  wire       clk,
    input  wire       rst_n,
    pss_req_if.sink   req,
    pss_rsp_if.source rsp
);

    localparam int FILL_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [FILL_W-1:0]   cnt_reg, cnt_next;
    logic                rsp_valid_reg, rsp_valid_next;
    pss_pkg::rsp_word_t  rsp_data_reg, rsp_data_next;
    pss_pkg::cell_ctrl_t ctrl;

    pss_pkg::word_t      cell_data [CAPACITY];

    logic                out_free;
    logic                accept;
    logic [pss_pkg::POS_W-1:0] fill_ext;
    logic [pss_pkg::POS_W-1:0] tail;
    logic                dump_last;

    // Cell chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        pss_pkg::word_t left_w;
        pss_pkg::word_t right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = cell_data[i+1];
        end

        pss_cell #(
            .IDX (i)
        ) u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .left  (left_w),
            .right (right_w),
            .data  (cell_data[i])
        );
    end

    // Handshake
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    assign fill_ext  = pss_pkg::POS_W'(fill_reg);
    assign tail      = fill_ext - pss_pkg::POS_W'(1);
    assign dump_last = (cnt_reg == fill_reg - FILL_W'(1));

    // Command decode and sequencing
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_data_next  = rsp_data_reg;
        ctrl.op        = pss_pkg::CELL_HOLD;
        ctrl.pos       = '0;
        ctrl.tail      = tail;
        ctrl.word      = req.data.value;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_data_next.status  = pss_pkg::STAT_DONE;
                    rsp_data_next.element = '0;
                    rsp_data_next.last    = 1'b1;
                    case (req.data.command)
                        pss_pkg::CMD_INSERT:
                        begin
                            if (fill_reg == FILL_W'(CAPACITY))
                                rsp_data_next.status = pss_pkg::STAT_FULL;
                            else
                            begin
                                ctrl.op   = pss_pkg::CELL_INSERT;
                                ctrl.pos  = (req.data.position > fill_ext) ?
                                            fill_ext : req.data.position;
                                fill_next = fill_reg + FILL_W'(1);
                            end
                        end
                        pss_pkg::CMD_DELETE:
                        begin
                            if (fill_reg == '0)
                                rsp_data_next.status = pss_pkg::STAT_UNDERFLOW;
                            else
                            begin
                                ctrl.op   = pss_pkg::CELL_DELETE;
                                ctrl.pos  = (req.data.position > tail) ?
                                            tail : req.data.position;
                                fill_next = fill_reg - FILL_W'(1);
                            end
                        end
                        pss_pkg::CMD_DUMP:
                        begin
                            if (fill_reg == '0)
                                rsp_data_next.status = pss_pkg::STAT_EMPTY;
                            else
                            begin
                                // words come out of the head cell from next cycle
                                rsp_valid_next = 1'b0;
                                cnt_next       = '0;
                                state_next     = S_DUMP;
                            end
                        end
                        default:
                        begin
                            rsp_data_next.status = pss_pkg::STAT_DONE;
                        end
                    endcase
                    rsp_data_next.length = pss_pkg::LEN_W'(fill_next);
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_data_next.status  = pss_pkg::STAT_ELEMENT;
                    rsp_data_next.element = cell_data[0];
                    rsp_data_next.length  = pss_pkg::LEN_W'(fill_reg);
                    rsp_data_next.last    = dump_last;
                    ctrl.op               = pss_pkg::CELL_ROTATE;
                    ctrl.word             = cell_data[0];
                    cnt_next              = cnt_reg + FILL_W'(1);
                    if (dump_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

endmodule

`default_nettype wire

>>> rtl/pss_cell.sv
// ----------------------------------------------------------------------------
// pss_cell
// One storage cell of the chain. Holds one word and, depending on the
// broadcast op and its own index, keeps it, takes the new word, or takes
// the word of its left or right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module pss_cell #(
    parameter int IDX = 0
) (
    input  wire                      clk,
    input  wire pss_pkg::cell_ctrl_t ctrl,
    input  wire pss_pkg::word_t      left,
    input  wire pss_pkg::word_t      right,
    output pss_pkg::word_t           data
);

    localparam logic [pss_pkg::POS_W-1:0] MY_IDX = pss_pkg::POS_W'(IDX);

    pss_pkg::word_t data_reg;
    pss_pkg::word_t data_next;

    // Next word selection
    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            pss_pkg::CELL_INSERT:
            begin
                if (MY_IDX == ctrl.pos)
                    data_next = ctrl.word;
                else if (MY_IDX > ctrl.pos)
                    data_next = left;
            end
            pss_pkg::CELL_DELETE:
            begin
                if (MY_IDX >= ctrl.pos)
                    data_next = right;
            end
            pss_pkg::CELL_ROTATE:
            begin
                // head word wraps to the tail, the rest move toward index 0
                if (MY_IDX == ctrl.tail)
                    data_next = ctrl.word;
                else if (MY_IDX < ctrl.tail)
                    data_next = right;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

>>> rtl/pss_checker.sv
// ----------------------------------------------------------------------------
// pss_assertions
// Port-level checks for positional_sequence_store_core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module pss_assertions (
    input wire                     clk,
    input wire                     rst_n,
    input wire                     req_valid,
    input wire                     req_ready,
    input wire                     rsp_valid,
    input wire                     rsp_ready,
    input wire pss_pkg::rsp_word_t rsp_data
);

    // A stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response word changed while stalled");

    // Only dumped elements carry a nonzero element field
    a_elem_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != pss_pkg::STAT_ELEMENT
            |-> rsp_data.element == '0)
        else $error("element field nonzero outside a dump");

    // Every result other than a dumped element is the only result of its request
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != pss_pkg::STAT_ELEMENT |-> rsp_data.last)
        else $error("single result without last marker");

    // No request is taken while a dump still has words to send
    a_no_accept_mid_dump: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> !(rsp_valid && !rsp_data.last))
        else $error("request accepted during a dump");

    // Consecutive dumped words report the same length
    a_dump_length: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && rsp_data.status == pss_pkg::STAT_ELEMENT
            && !rsp_data.last ##1 rsp_valid
            |-> rsp_data.status == pss_pkg::STAT_ELEMENT
                && rsp_data.length == $past(rsp_data.length))
        else $error("dump interrupted or length changed");

endmodule

bind positional_sequence_store_core pss_assertions u_pss_assertions (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

`default_nettype wire

>>> tb/sv/pss_checker.sv
// ----------------------------------------------------------------------------
// pss_checker
// Watches the request and response channels of the positional sequence
// store. It keeps its own copy of the stored sequence, works out the response
// words that every accepted request causes, and compares each accepted
// response word field by field with the oldest one still due.
// ----------------------------------------------------------------------------

module pss_checker #(
    parameter int CAPACITY = 32
) (
    input  logic clk,
    input  logic rst_n,
    pss_req_if   req,
    pss_rsp_if   rsp,
    output int   fails,
    output int   due_count,
    output int   words_checked,
    output int   full_drops,
    output int   underflows
);
    timeunit 1ns;
    timeprecision 1ps;

    import pss_pkg::*;

    // Mirror of the stored sequence, index 0 at the head
    word_t     held_words[$];
    // Response words still owed by the block, oldest first
    rsp_word_t due_words[$];

    initial
    begin
        fails         = 0;
        due_count     = 0;
        words_checked = 0;
        full_drops    = 0;
        underflows    = 0;
    end

    // Update the mirror for one request and queue the words it causes
    task automatic apply_command(input req_word_t w);
        rsp_word_t r;
        int        at;
        int        n;
        r        = '0;
        r.status = STAT_DONE;
        r.last   = 1'b1;
        case (w.command)
            CMD_INSERT:
            begin
                if (held_words.size() >= CAPACITY)
                begin
                    r.status = STAT_FULL;
                    full_drops++;
                end
                else
                begin
                    // past the end means append
                    at = (int'(w.position) > held_words.size()) ?
                         held_words.size() : int'(w.position);
                    held_words.insert(at, w.value);
                end
                r.length = LEN_W'(held_words.size());
                due_words.push_back(r);
            end
            CMD_DELETE:
            begin
                if (held_words.size() == 0)
                begin
                    r.status = STAT_UNDERFLOW;
                    underflows++;
                end
                else
                begin
                    // past the end removes the tail
                    at = (int'(w.position) > held_words.size() - 1) ?
                         held_words.size() - 1 : int'(w.position);
                    held_words.delete(at);
                end
                r.length = LEN_W'(held_words.size());
                due_words.push_back(r);
            end
            CMD_DUMP:
            begin
                n = held_words.size();
                r.length = LEN_W'(n);
                if (n == 0)
                begin
                    r.status = STAT_EMPTY;
                    due_words.push_back(r);
                end
                else
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        r.status  = STAT_ELEMENT;
                        r.element = held_words[i];
                        r.last    = (i == n - 1);
                        due_words.push_back(r);
                    end
                end
            end
            default:
            begin
                // spare code: state untouched, plain done word
                r.length = LEN_W'(held_words.size());
                due_words.push_back(r);
            end
        endcase
    endtask

    // Compare one response word against the oldest due word
    task automatic check_word(input rsp_word_t got);
        rsp_word_t want;
        if (due_words.size() == 0)
        begin
            $error("unexpected response word: status %0d element %0d length %0d last %0d",
                   got.status, got.element, got.length, got.last);
            fails++;
            return;
        end
        want = due_words.pop_front();
        words_checked++;
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fails++;
        end
        if (got.element !== want.element)
        begin
            $error("element: expected %0d, got %0d", want.element, got.element);
            fails++;
        end
        if (got.length !== want.length)
        begin
            $error("length: expected %0d, got %0d", want.length, got.length);
            fails++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            fails++;
        end
    endtask

    // Sample both channels at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_words.delete();
            due_words.delete();
            due_count <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
                apply_command(req.data);
            if (rsp.valid && rsp.ready)
                check_word(rsp.data);
            due_count <= due_words.size();
        end
    end

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the positional sequence store with a short directed run and then
// random bursts that fill, drain and mix the store, under three idling
// patterns and one long response hold-off. The checker beside the block
// predicts and compares every response word; this module gives the verdict.
// ----------------------------------------------------------------------------

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pss_pkg::*;

    localparam int         CAPACITY     = 32;
    localparam int         CLK_PERIOD   = 10;
    localparam int         LIMIT_CYCLES = 400000;
    localparam int         TAIL_CYCLES  = 40;
    localparam int         HOLD_CYCLES  = 200;
    // command code the block has no use for
    localparam logic [1:0] CMD_SPARE    = 2'd3;

    typedef enum int {
        MODE_FILL,
        MODE_GROW,
        MODE_SHRINK,
        MODE_MIXED
    } burst_mode_t;

    logic clk = 1'b0;
    logic rst_n;
    logic hold_req;
    int   send_idle;
    int   rcv_idle;
    int   sent_by_cmd [4];
    int   cycles;

    int fails;
    int due_count;
    int words_checked;
    int full_drops;
    int underflows;

    pss_req_if req_ch ();
    pss_rsp_if rsp_ch ();

    positional_sequence_store_core #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    pss_checker #(
        .CAPACITY (CAPACITY)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .fails         (fails),
        .due_count     (due_count),
        .words_checked (words_checked),
        .full_drops    (full_drops),
        .underflows    (underflows)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic req_word_t req_of(input logic [1:0] cmd, input word_t val,
                                         input logic [POS_W-1:0] pos);
        req_word_t w;
        w.command  = cmd;
        w.value    = val;
        w.position = pos;
        return w;
    endfunction

    // Random request shaped by the burst mode
    function automatic req_word_t random_word(input burst_mode_t mode, input bit closing);
        req_word_t  w;
        int         pick;
        w.command = CMD_INSERT;
        pick      = $urandom_range(99);
        case (mode)
            MODE_FILL:
                w.command = closing ? CMD_DUMP : CMD_INSERT;
            MODE_GROW:
                w.command = (pick < 80) ? CMD_INSERT : (pick < 88) ? CMD_DUMP :
                            (pick < 96) ? CMD_DELETE : CMD_SPARE;
            MODE_SHRINK:
                w.command = (pick < 75) ? CMD_DELETE : (pick < 85) ? CMD_INSERT :
                            (pick < 95) ? CMD_DUMP : CMD_SPARE;
            default:
                w.command = (pick < 40) ? CMD_INSERT : (pick < 75) ? CMD_DELETE :
                            (pick < 95) ? CMD_DUMP : CMD_SPARE;
        endcase
        case ($urandom_range(7))
            0:       w.value = 32'sh8000_0000;
            1:       w.value = 32'sh7fff_ffff;
            2:       w.value = -32'sd1;
            3:       w.value = '0;
            default: w.value = $urandom();
        endcase
        // mostly within the capacity or a little past it, now and then anywhere
        w.position = ($urandom_range(99) < 10) ? POS_W'($urandom_range(255)) :
                                                 POS_W'($urandom_range(CAPACITY + 3));
        return w;
    endfunction

    // Offer one word, called just after a rising edge
    task automatic send_word(input req_word_t w);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle)
            gap++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= w;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sent_by_cmd[w.command]++;
    endtask

    // Edges of every field and the special cases short of a full store
    task automatic run_directed();
        send_word(req_of(CMD_DUMP,   32'sd0,          8'd0));    // empty dump
        send_word(req_of(CMD_DELETE, 32'sd0,          8'd0));    // underflow
        send_word(req_of(CMD_DELETE, -32'sd1,         8'd255));
        send_word(req_of(CMD_SPARE,  32'sh7fff_ffff,  8'd255));  // spare on empty
        send_word(req_of(CMD_INSERT, 32'sh7fff_ffff,  8'd255));  // append past end
        send_word(req_of(CMD_INSERT, 32'sh8000_0000,  8'd0));
        send_word(req_of(CMD_INSERT, -32'sd1,         8'd1));
        send_word(req_of(CMD_INSERT, 32'sd0,          8'd200));
        send_word(req_of(CMD_INSERT, 32'sd1,          8'd2));
        send_word(req_of(CMD_DUMP,   32'sh1234_5678,  8'd77));
        send_word(req_of(CMD_DELETE, 32'sd0,          8'd255));  // drop the tail
        send_word(req_of(CMD_DELETE, 32'sd0,          8'd0));
        send_word(req_of(CMD_DELETE, 32'sd0,          8'd1));
        send_word(req_of(CMD_DUMP,   32'sd0,          8'd0));
        send_word(req_of(CMD_SPARE,  32'sh8000_0000,  8'd0));    // spare, not empty
        send_word(req_of(CMD_INSERT, 32'sh5555_5555,  8'haa));
        send_word(req_of(CMD_INSERT, 32'shaaaa_aaaa,  8'h55));
        send_word(req_of(CMD_DUMP,   32'sd0,          8'd0));
        send_word(req_of(CMD_DELETE, 32'sd0,          8'd7));
        send_word(req_of(CMD_DELETE, 32'sd0,          8'd0));
        send_word(req_of(CMD_DELETE, 32'sd0,          8'h80));
        send_word(req_of(CMD_DELETE, 32'sd0,          8'd255));
        send_word(req_of(CMD_DUMP,   32'sd0,          8'd0));
    endtask

    // Random bursts, the first one filling the store past capacity
    task automatic run_random(input int count);
        int          n;
        int          len;
        burst_mode_t mode;
        n    = 0;
        mode = MODE_FILL;
        while (n < count)
        begin
            len = (mode == MODE_FILL) ? CAPACITY + 3 : $urandom_range(16, 40);
            for (int i = 0; i < len && n < count; i++)
            begin
                send_word(random_word(mode, i == len - 1));
                n++;
            end
            mode = burst_mode_t'($urandom_range(3));
        end
    endtask

    // Response side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        bit hold_taken;
        hold_left    = 0;
        hold_taken   = 1'b0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rst_n        = 1'b0;
        hold_req     = 1'b0;
        send_idle    = 33;
        rcv_idle     = 51;
        for (int i = 0; i < 4; i++)
            sent_by_cmd[i] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(150);
        send_idle <= 51;
        rcv_idle  <= 33;
        run_random(150);
        // no idling, long response hold-off while requests keep coming
        send_idle <= 0;
        rcv_idle  <= 0;
        hold_req  <= 1'b1;
        run_random(150);
        req_ch.valid <= 1'b0;

        // drain, then let the block settle
        @(posedge clk);
        while (due_count != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d words: %0d inserts, %0d deletes, %0d dumps, %0d spare codes.",
                 sent_by_cmd[0] + sent_by_cmd[1] + sent_by_cmd[2] + sent_by_cmd[3],
                 sent_by_cmd[CMD_INSERT], sent_by_cmd[CMD_DELETE],
                 sent_by_cmd[CMD_DUMP], sent_by_cmd[CMD_SPARE]);
        $display("Checked %0d response words, %0d full drops, %0d underflows, %0d cycles.",
                 words_checked, full_drops, underflows, cycles);
        if (fails == 0 && due_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
